[src/csv_field_tokenizer_macros.svh]
// Assertion macros for the CSV field tokenizer checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSVFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csv tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define CSVFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csv tokenizer assertion failed");

`endif

[src/csvft_pkg.sv]
// Shared types and constants for the CSV field tokenizer.
// No dependencies.
package csvft_pkg;

  localparam int unsigned UnitW = 16;

  typedef logic [UnitW-1:0] unit_t;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  localparam unit_t QuoteUnit    = unit_t'(16'h0022);
  localparam unit_t SepResetUnit = unit_t'(16'h002C);

endpackage

[src/csv_field_tokenizer.sv]
// CSV field tokenizer: input register, one pass of flag and compare logic, result register.
// Depends on csvft_pkg.
// A result beat is formed from an input beat held in the input register and is then held in the result register.
// Throughput: one beat per cycle; the pass is two state flags and two 16-bit compares.
// Input stalls only while a beat waits in the input register behind an untaken result beat.
// Reset (rst_ni low, asynchronous): registers empty, quote flags clear, separator comma.
module csv_field_tokenizer
  import csvft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: separator code unit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  unit_t       cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  unit_t       s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // command: end of line
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output unit_t       m_axis_tdata,   // [15:0] char_out
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  unit_t sep_q;
  logic  in_v_q;
  logic  in_last_q;
  unit_t in_unit_q;
  logic  in_quotes_q, in_quotes_d;
  logic  pend_q, pend_d;
  logic  out_v_q;
  unit_t out_char_q;
  kind_e out_kind_q;

  logic  advance;
  logic  emit;
  kind_e kind_d;
  unit_t char_d;
  logic  iq_eff;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  always_comb begin
    in_quotes_d = in_quotes_q;
    pend_d      = pend_q;
    emit        = 1'b0;
    kind_d      = KIND_CHAR;
    char_d      = '0;
    iq_eff      = in_quotes_q;
    if (in_last_q) begin
      in_quotes_d = 1'b0;
      pend_d      = 1'b0;
      emit        = 1'b1;
      kind_d      = KIND_LINE_END;
    end else if (pend_q && in_unit_q == QuoteUnit) begin
      pend_d      = 1'b0;
      in_quotes_d = 1'b1;
      emit        = 1'b1;
      char_d      = QuoteUnit;
    end else begin
      if (pend_q) begin
        iq_eff = 1'b0;
      end
      pend_d      = 1'b0;
      in_quotes_d = iq_eff;
      if (in_unit_q == QuoteUnit) begin
        if (iq_eff) begin
          pend_d = 1'b1;
        end else begin
          in_quotes_d = 1'b1;
        end
      end else if (!iq_eff && in_unit_q == sep_q) begin
        emit   = 1'b1;
        kind_d = KIND_FIELD_END;
      end else begin
        emit   = 1'b1;
        char_d = in_unit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= SepResetUnit;
      in_v_q      <= 1'b0;
      in_quotes_q <= 1'b0;
      pend_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        sep_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        in_quotes_q <= in_quotes_d;
        pend_q      <= pend_d;
        out_v_q     <= emit;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_last_q <= s_axis_tlast;
      in_unit_q <= s_axis_tdata;
    end
    if (advance && emit) begin
      out_kind_q <= kind_d;
      out_char_q <= char_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

[src/csvft_checker.sv]
// Port-level checker for the CSV field tokenizer, bound to csv_field_tokenizer.
// Depends on csvft_pkg and csv_field_tokenizer_macros.svh.
`include "csv_field_tokenizer_macros.svh"

module csvft_checker
  import csvft_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input unit_t      m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  `CSVFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `CSVFT_ASSERT_NOW(a_kind_legal, m_axis_tvalid, m_axis_tuser <= KIND_LINE_END)
  `CSVFT_ASSERT_NOW(a_mark_zero, m_axis_tvalid && m_axis_tuser != KIND_CHAR, m_axis_tdata == '0)
  `CSVFT_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind csv_field_tokenizer csvft_checker u_csvft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
